### src/qcd_pkg.sv
// ----------------------------------------------------------------------------
// qcd_pkg
// Shared types and constants of the QOI chunk decoder: op tags, biases and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qcd_pkg;

  localparam int TABLE_DEPTH = 64;

  localparam logic [7:0] TAG_RGB  = 8'hFE;
  localparam logic [7:0] TAG_RGBA = 8'hFF;

  localparam logic [1:0] OP_INDEX = 2'b00;
  localparam logic [1:0] OP_DIFF  = 2'b01;
  localparam logic [1:0] OP_LUMA  = 2'b10;
  localparam logic [1:0] OP_RUN   = 2'b11;

  localparam logic [7:0] RESET_ALPHA  = 8'd255;
  localparam logic [7:0] DIFF_BIAS    = 8'd2;
  localparam logic [7:0] LUMA_G_BIAS  = 8'd32;
  localparam logic [7:0] LUMA_RB_BIAS = 8'd8;

  localparam logic [2:0] RGB_BYTES  = 3'd3;
  localparam logic [2:0] RGBA_BYTES = 3'd4;
  localparam logic [2:0] LUMA_BYTES = 3'd1;

  typedef struct packed {
    logic take;      // accept a stream byte and decode it
    logic load_idx;  // copy the fetched table entry into the pixel
    logic store;     // write the pixel into the color table
    logic emit;      // load one pixel into the output register
  } cmd_t;

  typedef struct packed {
    logic done;         // image complete, bytes are dropped
    logic op_index;     // incoming byte is an index op
    logic op_complete;  // incoming byte finishes an op with the pixel ready
    logic out_free;     // output register can take a pixel
    logic burst_last;   // next pixel is the last of the burst
  } stat_t;

endpackage

`default_nettype wire

### src/qcd_ram.sv
// ----------------------------------------------------------------------------
// qcd_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module qcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/qcd_ctrl.sv
// ----------------------------------------------------------------------------
// qcd_ctrl
// Controller of the QOI chunk decoder: sequences byte intake, table fetch,
// table store and pixel emission.
// ----------------------------------------------------------------------------
`default_nettype none

module qcd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire qcd_pkg::stat_t  stat,
  output qcd_pkg::cmd_t        cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_STORE = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && !stat.done) begin
          if (stat.op_index) begin
            state_nxt = S_FETCH;
          end else if (stat.op_complete) begin
            state_nxt = S_STORE;
          end
        end
      end
      S_FETCH: begin
        cmd.load_idx = 1'b1;
        state_nxt    = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = stat.out_free;
        if (stat.out_free && stat.burst_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/qcd_dpath.sv
// ----------------------------------------------------------------------------
// qcd_dpath
// Datapath of the QOI chunk decoder: op decode, previous pixel, color table
// with valid bits, pixel counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qcd_dpath #(
  parameter int TABLE_DEPTH = qcd_pkg::TABLE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [7:0]      in_stream_byte,
  input  wire logic            cfg_wr_en,
  input  wire logic [31:0]     cfg_wr_data,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output logic      [7:0]      out_red,
  output logic      [7:0]      out_green,
  output logic      [7:0]      out_blue,
  output logic      [7:0]      out_alpha,
  output logic                 out_last_of_burst,
  output logic                 out_image_done,
  input  wire qcd_pkg::cmd_t   cmd,
  output qcd_pkg::stat_t       stat
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [31:0]        pixel_count_r;
  logic [31:0]        emitted_r, emitted_nxt;
  logic               phase_data_r, phase_data_nxt;
  logic [7:0]         pending_tag_r, pending_tag_nxt;
  logic [2:0]         bytes_left_r, bytes_left_nxt;
  logic [7:0]         red_r, red_nxt, green_r, green_nxt;
  logic [7:0]         blue_r, blue_nxt, alpha_r, alpha_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic               out_valid_r;
  logic [7:0]         out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic               out_last_r, out_done_r;

  logic [7:0]         b;
  logic [1:0]         op;
  logic               is_rgbx;
  logic               take_live;
  logic [2:0]         total;
  logic [1:0]         pos;
  logic [7:0]         vg;
  logic [11:0]        hash_sum;
  logic [IDX_W-1:0]   hash_idx;
  logic [31:0]        emitted_inc;
  logic [31:0]        rd_data;

  assign b           = in_stream_byte;
  assign op          = b[7:6];
  assign is_rgbx     = (b == qcd_pkg::TAG_RGB) || (b == qcd_pkg::TAG_RGBA);
  assign take_live   = cmd.take && !stat.done;
  assign total       = (pending_tag_r == qcd_pkg::TAG_RGBA) ? qcd_pkg::RGBA_BYTES
                                                            : qcd_pkg::RGB_BYTES;
  assign pos         = 2'(total - bytes_left_r);
  assign vg          = {2'b00, pending_tag_r[5:0]} - qcd_pkg::LUMA_G_BIAS;
  assign emitted_inc = emitted_r + 32'd1;

  assign hash_sum = {4'b0, red_r} * 12'd3 + {4'b0, green_r} * 12'd5
                  + {4'b0, blue_r} * 12'd7 + {4'b0, alpha_r} * 12'd11;
  assign hash_idx = hash_sum[IDX_W-1:0];

  assign stat.done        = emitted_r >= pixel_count_r;
  assign stat.op_index    = !phase_data_r && !is_rgbx && (op == qcd_pkg::OP_INDEX);
  assign stat.op_complete = phase_data_r ? (bytes_left_r == 3'd1)
                          : (!is_rgbx && (op == qcd_pkg::OP_DIFF || op == qcd_pkg::OP_RUN));
  assign stat.out_free    = !out_valid_r || out_ready;
  assign stat.burst_last  = (cnt_r == 7'd1) || (emitted_inc == pixel_count_r);

  qcd_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.store),
    .wr_addr (hash_idx),
    .wr_data ({red_r, green_r, blue_r, alpha_r}),
    .rd_en   (take_live && stat.op_index),
    .rd_addr (b[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    phase_data_nxt  = phase_data_r;
    pending_tag_nxt = pending_tag_r;
    bytes_left_nxt  = bytes_left_r;
    red_nxt         = red_r;
    green_nxt       = green_r;
    blue_nxt        = blue_r;
    alpha_nxt       = alpha_r;
    cnt_nxt         = cnt_r;
    emitted_nxt     = emitted_r;
    if (take_live) begin
      cnt_nxt = 7'd1;
      if (phase_data_r) begin
        if (pending_tag_r == qcd_pkg::TAG_RGB || pending_tag_r == qcd_pkg::TAG_RGBA) begin
          case (pos)
            2'd0:    red_nxt   = b;
            2'd1:    green_nxt = b;
            2'd2:    blue_nxt  = b;
            default: alpha_nxt = b;
          endcase
        end else begin
          red_nxt   = red_r + vg - qcd_pkg::LUMA_RB_BIAS + {4'b0, b[7:4]};
          green_nxt = green_r + vg;
          blue_nxt  = blue_r + vg - qcd_pkg::LUMA_RB_BIAS + {4'b0, b[3:0]};
        end
        bytes_left_nxt = bytes_left_r - 3'd1;
        if (bytes_left_r == 3'd1) begin
          phase_data_nxt = 1'b0;
        end
      end else begin
        pending_tag_nxt = b;
        if (is_rgbx) begin
          phase_data_nxt = 1'b1;
          bytes_left_nxt = (b == qcd_pkg::TAG_RGBA) ? qcd_pkg::RGBA_BYTES
                                                    : qcd_pkg::RGB_BYTES;
        end else begin
          case (op)
            qcd_pkg::OP_DIFF: begin
              red_nxt   = red_r + {6'b0, b[5:4]} - qcd_pkg::DIFF_BIAS;
              green_nxt = green_r + {6'b0, b[3:2]} - qcd_pkg::DIFF_BIAS;
              blue_nxt  = blue_r + {6'b0, b[1:0]} - qcd_pkg::DIFF_BIAS;
            end
            qcd_pkg::OP_LUMA: begin
              phase_data_nxt = 1'b1;
              bytes_left_nxt = qcd_pkg::LUMA_BYTES;
            end
            qcd_pkg::OP_RUN: begin
              cnt_nxt = {1'b0, b[5:0]} + 7'd1;
            end
            default: begin
            end
          endcase
        end
      end
    end
    if (cmd.load_idx) begin
      if (valid_r[idx_r]) begin
        {red_nxt, green_nxt, blue_nxt, alpha_nxt} = rd_data;
      end else begin
        {red_nxt, green_nxt, blue_nxt, alpha_nxt} = '0;
      end
    end
    if (cmd.emit) begin
      cnt_nxt     = cnt_r - 7'd1;
      emitted_nxt = emitted_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r <= 32'd1;
      emitted_r     <= '0;
      phase_data_r  <= 1'b0;
      pending_tag_r <= '0;
      bytes_left_r  <= '0;
      red_r         <= '0;
      green_r       <= '0;
      blue_r        <= '0;
      alpha_r       <= qcd_pkg::RESET_ALPHA;
      valid_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pixel_count_r <= cfg_wr_data;
      end
      emitted_r     <= emitted_nxt;
      phase_data_r  <= phase_data_nxt;
      pending_tag_r <= pending_tag_nxt;
      bytes_left_r  <= bytes_left_nxt;
      red_r         <= red_nxt;
      green_r       <= green_nxt;
      blue_r        <= blue_nxt;
      alpha_r       <= alpha_nxt;
      if (cmd.store) begin
        valid_r[hash_idx] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (take_live) begin
      idx_r <= b[IDX_W-1:0];
    end
    if (cmd.emit) begin
      out_red_r   <= red_r;
      out_green_r <= green_r;
      out_blue_r  <= blue_r;
      out_alpha_r <= alpha_r;
      out_last_r  <= stat.burst_last;
      out_done_r  <= emitted_inc == pixel_count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red           = out_red_r;
  assign out_green         = out_green_r;
  assign out_blue          = out_blue_r;
  assign out_alpha         = out_alpha_r;
  assign out_last_of_burst = out_last_r;
  assign out_image_done    = out_done_r;

endmodule

`default_nettype wire

### src/qoi_chunk_decoder.sv
// ----------------------------------------------------------------------------
// qoi_chunk_decoder
// Decodes the QOI chunk byte stream into RGBA pixels, one byte per beat in,
// one pixel per beat out.
//
//   channel  ports                         dir  beat
//   input    in_valid/in_ready             in   one chunk byte
//   output   out_valid/out_ready           out  one RGBA pixel plus flags
//   config   cfg_wr_en/cfg_wr_data         in   pixel_count, no wait
//
// A byte that does not finish an op, or arrives after the image is complete,
// is simply taken. A finished op goes through intake, the color table write
// and then pixel emission, one pixel per cycle while the output side keeps up;
// INDEX adds a registered table read before the table write, and a run of n
// emits n pixels. Intake stops while pixels of an op are emitted.
// Reset clears the table valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_chunk_decoder #(
  parameter int TABLE_DEPTH = qcd_pkg::TABLE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_stream_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  out_red,
  output logic      [7:0]  out_green,
  output logic      [7:0]  out_blue,
  output logic      [7:0]  out_alpha,
  output logic             out_last_of_burst,
  output logic             out_image_done,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);

  qcd_pkg::cmd_t  cmd;
  qcd_pkg::stat_t stat;

  qcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  qcd_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_stream_byte    (in_stream_byte),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_alpha         (out_alpha),
    .out_last_of_burst (out_last_of_burst),
    .out_image_done    (out_image_done),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

`default_nettype wire

### src/qcd_checker.sv
// ----------------------------------------------------------------------------
// qcd_checker
// Port-level checks of the QOI chunk decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qcd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_alpha,
  input wire logic       out_last_of_burst,
  input wire logic       out_image_done
);

  // stalled pixel holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_alpha))
    else $error("output pixel changed while stalled");

  // the image's final pixel ends its burst
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_done |-> out_last_of_burst)
    else $error("image_done without last_of_burst");

  // more pixels of the same byte pending, so intake is closed
  a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_burst |-> !in_ready)
    else $error("byte accepted in the middle of a burst");

  // no pixel right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind qoi_chunk_decoder qcd_checker u_qcd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_red           (out_red),
  .out_alpha         (out_alpha),
  .out_last_of_burst (out_last_of_burst),
  .out_image_done    (out_image_done)
);

`default_nettype wire

### test/tb_qoi_chunk_decoder.sv
// ----------------------------------------------------------------------------
// tb_qoi_chunk_decoder
// Self-checking bench for the QOI chunk decoder. Chunk bytes go in over the
// input handshake, and every byte is decoded by a behavioral model of the
// op parser, color table and pixel counter. Each pixel beat that comes out is
// checked field by field against the oldest predicted pixel. Both sides idle
// at random, the receiver stalls once for a long stretch, and the pixel limit
// is changed between phases to hit completed images and runs cut short.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_qoi_chunk_decoder;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 70;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_PCT = 29;

  typedef enum logic {AT_TAG, AT_DATA} parse_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_of_burst;
    logic       image_done;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_stream_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        out_last_of_burst;
  logic        out_image_done;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'h0;

  // decoder model state
  parse_t          parse_st = AT_TAG;
  logic [7:0]      tag_held = 8'h00;
  logic [2:0]      left = 3'd0;
  logic [3:0][7:0] last_px = {qcd_pkg::RESET_ALPHA, 8'h00, 8'h00, 8'h00};
  logic [3:0][7:0] seen_colors [qcd_pkg::TABLE_DEPTH];
  logic [31:0]     pix_done = 32'd0;
  logic [31:0]     pix_limit = 32'd1;

  logic [7:0]  chunk_bytes [$];
  pixel_t      pixels_due [$];
  pixel_t      want_px;

  logic        calm = 1'b0;
  logic        hold_kick = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_taken = 0;
  int unsigned pixels_checked = 0;
  int unsigned limit_writes = 0;

  qoi_chunk_decoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_stream_byte    (in_stream_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_alpha         (out_alpha),
    .out_last_of_burst (out_last_of_burst),
    .out_image_done    (out_image_done),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    for (int i = 0; i < qcd_pkg::TABLE_DEPTH; i++) seen_colors[i] = '0;
  end

  // decode one accepted byte and queue the pixels it produces
  function automatic void decode_chunk_byte(input logic [7:0] b);
    logic [7:0]  vg;
    logic [2:0]  total;
    logic [1:0]  pos;
    logic [31:0] reps;
    logic [31:0] room;
    logic [31:0] n;
    int unsigned h;
    pixel_t      px;
    reps = 32'd1;
    if (pix_done >= pix_limit) return;
    if (parse_st == AT_DATA) begin
      if (tag_held == qcd_pkg::TAG_RGB || tag_held == qcd_pkg::TAG_RGBA) begin
        total = (tag_held == qcd_pkg::TAG_RGBA) ? qcd_pkg::RGBA_BYTES : qcd_pkg::RGB_BYTES;
        pos = 2'(total - left);
        last_px[pos] = b;
      end else begin
        vg = {2'b00, tag_held[5:0]} - qcd_pkg::LUMA_G_BIAS;
        last_px[0] = last_px[0] + vg - qcd_pkg::LUMA_RB_BIAS + {4'h0, b[7:4]};
        last_px[1] = last_px[1] + vg;
        last_px[2] = last_px[2] + vg - qcd_pkg::LUMA_RB_BIAS + {4'h0, b[3:0]};
      end
      left = left - 3'd1;
      if (left != 3'd0) return;
      parse_st = AT_TAG;
    end else begin
      tag_held = b;
      if (b == qcd_pkg::TAG_RGB || b == qcd_pkg::TAG_RGBA) begin
        left = (b == qcd_pkg::TAG_RGBA) ? qcd_pkg::RGBA_BYTES : qcd_pkg::RGB_BYTES;
        parse_st = AT_DATA;
        return;
      end
      case (b[7:6])
        qcd_pkg::OP_INDEX: last_px = seen_colors[b[5:0]];
        qcd_pkg::OP_DIFF: begin
          last_px[0] = last_px[0] + {6'b0, b[5:4]} - qcd_pkg::DIFF_BIAS;
          last_px[1] = last_px[1] + {6'b0, b[3:2]} - qcd_pkg::DIFF_BIAS;
          last_px[2] = last_px[2] + {6'b0, b[1:0]} - qcd_pkg::DIFF_BIAS;
        end
        qcd_pkg::OP_LUMA: begin
          left = qcd_pkg::LUMA_BYTES;
          parse_st = AT_DATA;
          return;
        end
        default: reps = {26'b0, b[5:0]} + 32'd1;
      endcase
    end
    h = 3 * last_px[0] + 5 * last_px[1] + 7 * last_px[2] + 11 * last_px[3];
    seen_colors[6'(h % qcd_pkg::TABLE_DEPTH)] = last_px;
    room = pix_limit - pix_done;
    n = (reps < room) ? reps : room;
    for (int unsigned k = 0; k < n; k++) begin
      pix_done = pix_done + 32'd1;
      px.red = last_px[0];
      px.green = last_px[1];
      px.blue = last_px[2];
      px.alpha = last_px[3];
      px.last_of_burst = (k + 1 == n);
      px.image_done = (pix_done == pix_limit);
      pixels_due.push_back(px);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (mismatches < 50)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got,
               exp_val);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_chunk_byte(in_stream_byte);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (chunk_bytes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_stream_byte <= chunk_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixels_due.size() == 0) begin
          report_mismatch("pixel beat with none expected", 32'(out_red), 32'd0);
        end else begin
          want_px = pixels_due.pop_front();
          if (out_red !== want_px.red)
            report_mismatch("red", 32'(out_red), 32'(want_px.red));
          if (out_green !== want_px.green)
            report_mismatch("green", 32'(out_green), 32'(want_px.green));
          if (out_blue !== want_px.blue)
            report_mismatch("blue", 32'(out_blue), 32'(want_px.blue));
          if (out_alpha !== want_px.alpha)
            report_mismatch("alpha", 32'(out_alpha), 32'(want_px.alpha));
          if (out_last_of_burst !== want_px.last_of_burst)
            report_mismatch("last_of_burst", 32'(out_last_of_burst),
                            32'(want_px.last_of_burst));
          if (out_image_done !== want_px.image_done)
            report_mismatch("image_done", 32'(out_image_done), 32'(want_px.image_done));
          pixels_checked++;
        end
      end
      out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still due", cycle_cnt,
               pixels_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (chunk_bytes.size() != 0 || in_valid || pixels_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pix_limit = v;
    limit_writes++;
    @(negedge clk);
  endtask

  // whole ops with random content, plus some raw noise bytes
  task automatic queue_random_chunks(input int unsigned count);
    int unsigned pushed;
    int unsigned sel;
    int unsigned len;
    pushed = 0;
    while (pushed < count) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        chunk_bytes.push_back(qcd_pkg::TAG_RGB);
        repeat (3) chunk_bytes.push_back(8'($urandom));
        pushed += 4;
      end else if (sel < 20) begin
        chunk_bytes.push_back(qcd_pkg::TAG_RGBA);
        repeat (4) chunk_bytes.push_back(8'($urandom));
        pushed += 5;
      end else if (sel < 38) begin
        chunk_bytes.push_back({qcd_pkg::OP_INDEX, 6'($urandom)});
        pushed += 1;
      end else if (sel < 58) begin
        chunk_bytes.push_back({qcd_pkg::OP_DIFF, 6'($urandom)});
        pushed += 1;
      end else if (sel < 75) begin
        chunk_bytes.push_back({qcd_pkg::OP_LUMA, 6'($urandom)});
        chunk_bytes.push_back(8'($urandom));
        pushed += 2;
      end else if (sel < 90) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(61) : $urandom_range(7);
        chunk_bytes.push_back({qcd_pkg::OP_RUN, 6'(len)});
        pushed += 1;
      end else begin
        chunk_bytes.push_back(8'($urandom));
        pushed += 1;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limit of one pixel, later bytes dropped
    chunk_bytes = {{qcd_pkg::OP_DIFF, 6'h15}, {qcd_pkg::OP_RUN, 6'd5}, qcd_pkg::TAG_RGBA};
    drain();
    write_limit(32'hFFFF_FFFF);

    // every op and its field extremes
    chunk_bytes = {qcd_pkg::TAG_RGB, 8'h00, 8'hFF, 8'h80,
                   qcd_pkg::TAG_RGBA, 8'h12, 8'h34, 8'h56, 8'h00,
                   {qcd_pkg::OP_INDEX, 6'h00}, {qcd_pkg::OP_INDEX, 6'h3F},
                   {qcd_pkg::OP_DIFF, 6'h00}, {qcd_pkg::OP_DIFF, 6'h3F},
                   {qcd_pkg::OP_DIFF, 6'h15},
                   {qcd_pkg::OP_LUMA, 6'h00}, 8'h00, {qcd_pkg::OP_LUMA, 6'h3F}, 8'hFF,
                   {qcd_pkg::OP_RUN, 6'd0}, {qcd_pkg::OP_RUN, 6'd61},
                   qcd_pkg::TAG_RGBA, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    drain();

    // no idling on either side
    calm = 1'b1;
    queue_random_chunks(60);
    drain();
    calm = 1'b0;

    queue_random_chunks(70);
    do @(negedge clk); while (chunk_bytes.size() > 20);
    hold_kick = ~hold_kick;
    chunk_bytes.push_back({qcd_pkg::OP_RUN, 6'd61});
    chunk_bytes.push_back({qcd_pkg::OP_RUN, 6'd40});
    queue_random_chunks(30);
    drain();
    while (parse_st == AT_DATA) begin
      repeat (left) chunk_bytes.push_back(8'($urandom));
      drain();
    end

    // run cut short at the limit, then an image already past its limit
    write_limit(pix_done + 32'd3);
    chunk_bytes = {{qcd_pkg::OP_RUN, 6'd61}, {qcd_pkg::OP_DIFF, 6'h2A},
                   qcd_pkg::TAG_RGB, 8'h00};
    drain();
    write_limit(32'd1);
    repeat (10) chunk_bytes.push_back(8'($urandom));
    drain();
    write_limit(32'hFFFF_FFFF);

    queue_random_chunks(20);
    drain();

    $display("covered all chunk ops, runs cut short, bytes after image end, stalls");
    $display("%0d bytes taken, %0d pixels checked, %0d limit writes", bytes_taken,
             pixels_checked, limit_writes);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### qoi_chunk_decoder.f
src/qcd_pkg.sv
src/qcd_ram.sv
src/qcd_ctrl.sv
src/qcd_dpath.sv
src/qoi_chunk_decoder.sv
src/qcd_checker.sv
test/tb_qoi_chunk_decoder.sv
